// File: src/assert_macros.svh
// Assertion macros shared by the page walker RTL.
// The assertions are clocked on clk and are held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cond must hold at every clock edge.
`define PTW_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ptw assertion failed");

// cons must hold in the same cycle as ante.
`define PTW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptw assertion failed");

// cons must hold in the cycle after ante.
`define PTW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptw assertion failed");

`else

`define PTW_ASSERT(lbl, cond)
`define PTW_ASSERT_IMP(lbl, ante, cons)
`define PTW_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: src/ptw_pkg.sv
package ptw_pkg;

  localparam int ADDR_W      = 32;
  localparam int PAGE_SHIFT  = 12;  // 4 KiB pages
  localparam int DIR_SHIFT   = 22;  // directory index = va[31:22]
  localparam int DIR_FRAME_W = 17;  // directory word frame bits 28:12
  localparam int FRAME_W     = 20;  // table word frame bits 31:12
  localparam int LOW_W       = 22;  // va bits kept during a walk

  // Table word flag bits
  localparam int PTE_PRESENT = 0;
  localparam int PTE_WRITE   = 1;
  localparam int PTE_KERNEL  = 2;

  // Input command codes
  localparam logic CMD_REQ  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // Result kind codes
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Configuration register indexes
  localparam int           CFG_IDX_W  = 1;
  localparam int           CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_PAGING_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_BASE    = 1'd1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DIR   = 2'd1,
    PH_TABLE = 2'd2
  } phase_t;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] virt_addr;
    logic              is_store;
    logic              kernel_mode;
    logic [ADDR_W-1:0] read_data;
  } ptw_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] address;
    logic              fault;
  } ptw_result_t;

  // Input register to walk stage
  typedef struct packed {
    logic      valid;
    ptw_item_t item;
  } ptw_stage_t;

  // Walk stage handshake back to the registers around it
  typedef struct packed {
    logic step;  // held item is consumed this cycle
    logic emit;  // held item produces a result
  } ptw_step_t;

endpackage

// File: src/ptw_in_if.sv
interface ptw_in_if import ptw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] virt_addr;
  logic              is_store;
  logic              kernel_mode;
  logic [ADDR_W-1:0] read_data;

  modport source (
    output valid, command, virt_addr, is_store, kernel_mode, read_data,
    input  ready
  );
  modport sink (
    input  valid, command, virt_addr, is_store, kernel_mode, read_data,
    output ready
  );
endinterface

// File: src/ptw_out_if.sv
interface ptw_out_if import ptw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [ADDR_W-1:0] address;
  logic              fault;

  modport source (
    output valid, result_kind, address, fault,
    input  ready
  );
  modport sink (
    input  valid, result_kind, address, fault,
    output ready
  );
endinterface

// File: src/ptw_in_stage.sv
module ptw_in_stage import ptw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ptw_item_t  in_item,
  input  ptw_step_t  walk_step,
  output ptw_stage_t stage
);

  logic      valid_r, valid_nxt;
  ptw_item_t item_r;
  logic      take;

  // Free when empty or when the held item leaves this cycle
  assign in_ready = !valid_r || walk_step.step;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (walk_step.step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// File: src/ptw_walk.sv
`include "assert_macros.svh"

module ptw_walk import ptw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ptw_stage_t            stage,
  input  logic                  out_free,
  output ptw_step_t             walk_step,
  output ptw_result_t           result
);

  logic              paging_en_r;
  logic [ADDR_W-1:0] table_base_r;

  phase_t            phase_r, phase_nxt;
  logic [LOW_W-1:0]  low_r, low_nxt;
  logic              store_r, store_nxt;
  logic              kernel_r, kernel_nxt;
  logic              dir_wr_r, dir_wr_nxt;
  logic              dir_ko_r, dir_ko_nxt;

  ptw_item_t         it;
  logic              emit;
  logic              step;
  logic              bad;
  logic [ADDR_W-1:0] dir_frame;
  logic [ADDR_W-1:0] tbl_off;
  logic [ADDR_W-1:0] dir_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_en_r  <= 1'b0;
      table_base_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PAGING_ENABLE: paging_en_r  <= cfg_wdata[0];
        REG_TABLE_BASE:    table_base_r <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign it = stage.item;

  // Address pieces
  assign dir_off   = {{(ADDR_W-(ADDR_W-DIR_SHIFT)-2){1'b0}},
                      it.virt_addr[ADDR_W-1:DIR_SHIFT], 2'b00};
  assign dir_frame = {{(ADDR_W-DIR_FRAME_W-PAGE_SHIFT){1'b0}},
                      it.read_data[PAGE_SHIFT+DIR_FRAME_W-1:PAGE_SHIFT],
                      {PAGE_SHIFT{1'b0}}};
  assign tbl_off   = {{(ADDR_W-(LOW_W-PAGE_SHIFT)-2){1'b0}},
                      low_r[LOW_W-1:PAGE_SHIFT], 2'b00};

  // Permission check on the table word
  always_comb begin
    bad = 1'b0;
    if (!it.read_data[PTE_PRESENT]) begin
      bad = 1'b1;
    end else if (!kernel_r && (it.read_data[PTE_KERNEL] || dir_ko_r)) begin
      bad = 1'b1;
    end else if (store_r && !(it.read_data[PTE_WRITE] && dir_wr_r)) begin
      bad = 1'b1;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    low_nxt    = low_r;
    store_nxt  = store_r;
    kernel_nxt = kernel_r;
    dir_wr_nxt = dir_wr_r;
    dir_ko_nxt = dir_ko_r;
    emit       = 1'b0;
    result     = '{result_kind: KIND_DONE, address: '0, fault: 1'b0};
    case (phase_r)
      PH_DIR: begin
        if (it.command == CMD_DATA) begin
          emit = 1'b1;
          if (!it.read_data[PTE_PRESENT]) begin
            phase_nxt    = PH_IDLE;
            result.fault = 1'b1;
          end else begin
            phase_nxt          = PH_TABLE;
            dir_wr_nxt         = it.read_data[PTE_WRITE];
            dir_ko_nxt         = it.read_data[PTE_KERNEL];
            result.result_kind = KIND_READ;
            result.address     = dir_frame + tbl_off;
          end
        end
      end
      PH_TABLE: begin
        if (it.command == CMD_DATA) begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
          if (bad) begin
            result.fault = 1'b1;
          end else begin
            result.address = {it.read_data[ADDR_W-1:PAGE_SHIFT],
                              low_r[PAGE_SHIFT-1:0]};
          end
        end
      end
      default: begin
        if (it.command == CMD_REQ) begin
          emit = 1'b1;
          if (!paging_en_r) begin
            result.address = it.virt_addr;
          end else begin
            phase_nxt          = PH_DIR;
            low_nxt            = it.virt_addr[LOW_W-1:0];
            store_nxt          = it.is_store;
            kernel_nxt         = it.kernel_mode;
            result.result_kind = KIND_READ;
            result.address     = table_base_r + dir_off;
          end
        end
      end
    endcase
  end

  // Dropped items never wait on the output side
  assign step = stage.valid && (!emit || out_free);

  assign walk_step.step = step;
  assign walk_step.emit = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      low_r    <= '0;
      store_r  <= 1'b0;
      kernel_r <= 1'b0;
      dir_wr_r <= 1'b0;
      dir_ko_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      low_r    <= low_nxt;
      store_r  <= store_nxt;
      kernel_r <= kernel_nxt;
      dir_wr_r <= dir_wr_nxt;
      dir_ko_r <= dir_ko_nxt;
    end
  end

  `PTW_ASSERT_NXT(a_table_ends_walk, step && phase_r == PH_TABLE && it.command == CMD_DATA, phase_r == PH_IDLE)
  `PTW_ASSERT_IMP(a_fault_zero_addr, emit && result.fault, result.address == '0 && result.result_kind == KIND_DONE)
  `PTW_ASSERT_IMP(a_emit_has_room, step && emit, out_free)
  `PTW_ASSERT_IMP(a_idle_no_emit_on_data, phase_r == PH_IDLE && it.command == CMD_DATA, !emit)

endmodule

// File: src/ptw_out_stage.sv
module ptw_out_stage import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ptw_step_t   walk_step,
  input  ptw_result_t result,
  input  logic        out_ready,
  output logic        out_valid,
  output ptw_result_t out_result,
  output logic        out_free
);

  logic        valid_r, valid_nxt;
  ptw_result_t result_r;
  logic        load;

  assign out_free = !valid_r || out_ready;
  assign load     = walk_step.step && walk_step.emit;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// File: src/two_level_page_walker_top.sv
// Two-level page table walker. Each transfer on the input channel is either a
// translate request (command 0) or a table word returned by memory (command 1).
// With paging_enable clear a request finishes at once with the address passed
// through. With it set, the walker emits a read request for the directory word,
// then on the returned word a read request for the table word (or a fault when
// the directory entry is not present), then on that word the finished physical
// address or a fault (address zero). Requests that arrive mid-walk and data
// that arrives while idle are dropped with no result.
// Rate: one input transfer per cycle while the output side does not back up.
// An accepted item is held in the input register; the walk logic decides it and
// loads any result into the result register, which offers it on the output. The
// result register lets the next item enter while a result still waits; the
// input side stalls only when a result is pending and out ready is low.
// Config writes are taken any cycle and must only be issued while idle.
module two_level_page_walker_top import ptw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ptw_in_if.sink                in_ch,
  ptw_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ptw_item_t   in_item;
  ptw_stage_t  stage;
  ptw_step_t   walk_step;
  ptw_result_t walk_result;
  ptw_result_t out_result;
  logic        out_free;

  assign in_item.command     = in_ch.command;
  assign in_item.virt_addr   = in_ch.virt_addr;
  assign in_item.is_store    = in_ch.is_store;
  assign in_item.kernel_mode = in_ch.kernel_mode;
  assign in_item.read_data   = in_ch.read_data;

  // Input register
  ptw_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .walk_step (walk_step),
    .stage     (stage)
  );

  // Walk state, config registers and the one-step decision logic
  ptw_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .out_free  (out_free),
    .walk_step (walk_step),
    .result    (walk_result)
  );

  // Result register
  ptw_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .walk_step  (walk_step),
    .result     (walk_result),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_result (out_result),
    .out_free   (out_free)
  );

  assign out_ch.result_kind = out_result.result_kind;
  assign out_ch.address     = out_result.address;
  assign out_ch.fault       = out_result.fault;

endmodule

// File: dv/two_level_page_walker_top_test.sv
`timescale 1ns / 100ps

module two_level_page_walker_top_test;
  import ptw_pkg::*;

  // Cycles to let dropped items clear the pipe before a register write.
  localparam int SETTLE_CYCLES = 4;
  // Length of the forced output hold that backs the walker up.
  localparam int LONG_HOLD     = 80;
  // Cycles with no transfer on either channel before the run is abandoned.
  localparam int QUIET_LIMIT   = 2000;
  // Transfers that produce a result, per random phase.
  localparam int PHASE_ITEMS   = 205;

  logic clk;
  logic rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ptw_in_if  in_ch ();
  ptw_out_if out_ch ();

  two_level_page_walker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Idle / stall knobs, percent of cycles.
  int src_idle_pct;
  int sink_stall_pct;
  // Set by a test to request one long output hold; cleared by the sink.
  bit sink_hold_go;
  int sink_hold_left;

  int mismatches;
  int n_requests;
  int n_words;
  int n_results;
  int n_faults;
  int n_productive;
  int n_settings;

  // ---------------------------------------------------------------------------
  // Predictor: walker state and registers, advanced once per input transfer.
  // ---------------------------------------------------------------------------
  bit          pg_on;
  logic [31:0] dir_base;
  phase_t      walk_phase;
  logic [21:0] walk_offset_bits;
  bit          walk_is_store;
  bit          walk_is_kernel;
  bit          pde_writable;
  bit          pde_kernel;

  ptw_result_t walk_results_due[$];

  function automatic void walker_reset();
    pg_on            = 1'b0;
    dir_base         = '0;
    walk_phase       = PH_IDLE;
    walk_offset_bits = '0;
    walk_is_store    = 1'b0;
    walk_is_kernel   = 1'b0;
    pde_writable     = 1'b0;
    pde_kernel       = 1'b0;
  endfunction

  // Returns 1 when the transfer produces a result, which lands in res.
  function automatic bit predict_walk_step(input ptw_item_t it, output ptw_result_t res);
    logic [31:0] rd;
    bit          denied;
    rd  = it.read_data;
    res = '0;
    // Anything but the two walk phases counts as idle.
    if (walk_phase != PH_DIR && walk_phase != PH_TABLE) begin
      if (it.command != CMD_REQ) return 1'b0;  // table word with no walk: dropped
      if (!pg_on) begin
        res.result_kind = KIND_DONE;
        res.address     = it.virt_addr;
        return 1'b1;
      end
      walk_offset_bits = it.virt_addr[21:0];
      walk_is_store    = it.is_store;
      walk_is_kernel   = it.kernel_mode;
      walk_phase       = PH_DIR;
      res.result_kind  = KIND_READ;
      res.address      = dir_base + {20'b0, it.virt_addr[31:22], 2'b00};
      return 1'b1;
    end
    if (it.command == CMD_REQ) return 1'b0;  // request mid-walk: dropped
    if (walk_phase == PH_DIR) begin
      if (!rd[PTE_PRESENT]) begin
        walk_phase      = PH_IDLE;
        res.result_kind = KIND_DONE;
        res.fault       = 1'b1;
        return 1'b1;
      end
      pde_writable    = rd[PTE_WRITE];
      pde_kernel      = rd[PTE_KERNEL];
      walk_phase      = PH_TABLE;
      res.result_kind = KIND_READ;
      // directory frame is bits 28:12 only
      res.address     = {3'b0, rd[28:12], 12'b0} + {20'b0, walk_offset_bits[21:12], 2'b00};
      return 1'b1;
    end
    walk_phase      = PH_IDLE;
    res.result_kind = KIND_DONE;
    denied = !rd[PTE_PRESENT]
          || (!walk_is_kernel && (rd[PTE_KERNEL] || pde_kernel))
          || (walk_is_store && !(rd[PTE_WRITE] && pde_writable));
    if (denied) res.fault = 1'b1;
    else        res.address = {rd[31:12], walk_offset_bits[11:0]};
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: checks output transfers, tracks register writes, predicts inputs.
  // Everything is sampled at the rising edge, before any update of that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    ptw_item_t   taken;
    ptw_result_t got;
    ptw_result_t oldest;
    ptw_result_t predicted;
    if (!rst_n) begin
      walker_reset();
    end else begin
      // Output side first: a result popped here always belongs to an older
      // input than one accepted on this same edge.
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind = out_ch.result_kind;
        got.address     = out_ch.address;
        got.fault       = out_ch.fault;
        if (walk_results_due.size() == 0) begin
          $error("result with nothing pending: kind %0b address 0x%08h fault %0b",
                 got.result_kind, got.address, got.fault);
          mismatches++;
        end else begin
          oldest = walk_results_due.pop_front();
          check_field("result_kind", 32'(oldest.result_kind), 32'(got.result_kind));
          check_field("address", oldest.address, got.address);
          check_field("fault", 32'(oldest.fault), 32'(got.fault));
          n_results++;
          if (got.fault) n_faults++;
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PAGING_ENABLE: pg_on    = cfg_wdata[0];
          REG_TABLE_BASE:    dir_base = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.command     = in_ch.command;
        taken.virt_addr   = in_ch.virt_addr;
        taken.is_store    = in_ch.is_store;
        taken.kernel_mode = in_ch.kernel_mode;
        taken.read_data   = in_ch.read_data;
        if (taken.command == CMD_REQ) n_requests++;
        else                          n_words++;
        if (predict_walk_step(taken, predicted)) begin
          walk_results_due.push_back(predicted);
          n_productive++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold on request from a test.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_hold_left != 0) begin
      out_ch.ready   <= 1'b0;
      sink_hold_left <= sink_hold_left - 1;
    end else if (sink_hold_go) begin
      sink_hold_go    = 1'b0;
      sink_hold_left <= LONG_HOLD;
      out_ch.ready   <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: gives up when neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d results still pending",
             QUIET_LIMIT, walk_results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic ptw_item_t request_item(logic [31:0] va, bit st, bit km);
    ptw_item_t it;
    it.command     = CMD_REQ;
    it.virt_addr   = va;
    it.is_store    = st;
    it.kernel_mode = km;
    it.read_data   = $urandom;  // unused on requests
    return it;
  endfunction

  function automatic ptw_item_t word_item(logic [31:0] rd);
    ptw_item_t it;
    it.command     = CMD_DATA;
    it.virt_addr   = $urandom;  // unused on data
    it.is_store    = 1'($urandom_range(1));
    it.kernel_mode = 1'($urandom_range(1));
    it.read_data   = rd;
    return it;
  endfunction

  // Table word with biased flags so that most walks get all the way through.
  function automatic logic [31:0] rand_table_word();
    logic [31:0] w;
    w              = $urandom;
    w[PTE_PRESENT] = ($urandom_range(99) < 90);
    w[PTE_WRITE]   = ($urandom_range(99) < 75);
    w[PTE_KERNEL]  = ($urandom_range(99) < 25);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver tasks. Entered and left at a rising edge; valid is left high after
  // the last transfer so that back-to-back items take one assignment per edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input ptw_item_t it);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= it.command;
    in_ch.virt_addr   <= it.virt_addr;
    in_ch.is_store    <= it.is_store;
    in_ch.kernel_mode <= it.kernel_mode;
    in_ch.read_data   <= it.read_data;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait for every predicted result, then let any dropped
  // items drain out of the pipe.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (walk_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Upper bits of the enable write are junk on purpose; only bit 0 counts.
  task automatic set_walker(input bit en, input logic [31:0] base);
    cfg_write(REG_TABLE_BASE, base);
    cfg_write(REG_PAGING_ENABLE, ($urandom & 32'hFFFF_FFFE) | 32'(en));
    n_settings++;
  endtask

  // One walk with random content; with paging off just the request.
  task automatic run_walk();
    logic [31:0] dir_w;
    dir_w = rand_table_word();
    send_item(request_item($urandom, 1'($urandom_range(1)), 1'($urandom_range(1))));
    if (!pg_on) return;
    if ($urandom_range(99) < 8)
      send_item(request_item($urandom, 1'($urandom_range(1)), 1'($urandom_range(1))));
    send_item(word_item(dir_w));
    if (dir_w[PTE_PRESENT]) send_item(word_item(rand_table_word()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // Paging is off out of reset: addresses come straight back.
    send_item(request_item(32'h0000_0000, 1'b0, 1'b0));
    send_item(request_item(32'hFFFF_FFFF, 1'b1, 1'b1));
    send_item(word_item(32'hFFFF_FFFF));  // table word while idle: dropped
    wait_drained();

    // Base near the top: directory index 0x3FF wraps the read address.
    cfg_write(REG_TABLE_BASE, 32'hFFFF_FFFC);
    cfg_write(REG_PAGING_ENABLE, 32'h0000_0001);
    n_settings++;

    // Kernel store, all bits set; second request is dropped mid-walk and the
    // directory frame must lose bits 31:29.
    send_item(request_item(32'hFFFF_FFFF, 1'b1, 1'b1));
    send_item(request_item(32'h1234_5678, 1'b0, 1'b0));
    send_item(word_item(32'hFFFF_FFFF));
    send_item(word_item(32'hFFFF_FFFF));
    // Directory entry not present.
    send_item(request_item(32'h0040_0000, 1'b0, 1'b0));
    send_item(word_item(32'hFFFF_FFFE));
    // User access to a kernel-only directory entry.
    send_item(request_item(32'h0080_1ABC, 1'b0, 1'b0));
    send_item(word_item(32'h0000_5005));
    send_item(word_item(32'h0000_7003));
    // User access to a kernel-only table entry.
    send_item(request_item(32'h00C0_2FFF, 1'b0, 1'b0));
    send_item(word_item(32'h0000_8003));
    send_item(word_item(32'h000A_1007));
    // Store through a read-only directory entry.
    send_item(request_item(32'h7FFF_F000, 1'b1, 1'b1));
    send_item(word_item(32'h1000_0005));
    send_item(word_item(32'h0001_2007));
    // Store to a read-only table entry.
    send_item(request_item(32'h8000_0001, 1'b1, 1'b1));
    send_item(word_item(32'h0000_3007));
    send_item(word_item(32'hABCD_E005));
    // Table entry not present.
    send_item(request_item(32'h0000_0000, 1'b0, 1'b1));
    send_item(word_item(32'h0000_0001));
    send_item(word_item(32'hFFFF_FFFE));
    wait_drained();

    // Paging switched off after the directory read went out: the walk still
    // finishes as a translation.
    send_item(request_item(32'h0000_3FFF, 1'b0, 1'b0));
    wait_drained();
    cfg_write(REG_PAGING_ENABLE, 32'h0000_0000);
    n_settings++;
    send_item(word_item(32'h0002_0003));
    send_item(word_item(32'h5555_5003));
    wait_drained();
  endtask

  // Hold the output for a long stretch while the input keeps offering full
  // walks, so the walker backs up and stalls its input.
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_walker(1'b1, $urandom);
    sink_hold_go = 1'b1;
    repeat (12) run_walk();
    wait_drained();
  endtask

  // Random walks mixed with stray items, through every idle mode and a range
  // of directory bases including both ends, with paging off in two phases.
  task automatic test_random_traffic();
    int target;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      case (ph)
        0:       set_walker(1'b1, 32'h0000_0000);
        1:       set_walker(1'b1, 32'hFFFF_FFFF);
        2:       set_walker(1'b1, 32'hFFFF_F000);
        3, 6:    set_walker(1'b0, $urandom);
        default: set_walker(1'b1, $urandom);
      endcase
      target = n_productive + PHASE_ITEMS;
      while (n_productive < target) begin
        if ($urandom_range(99) < 12) begin
          // stray item: either kind, any content
          if ($urandom_range(1)) send_item(word_item($urandom));
          else send_item(request_item($urandom, 1'($urandom_range(1)),
                                      1'($urandom_range(1))));
        end else begin
          run_walk();
        end
      end
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_REQ;
    in_ch.virt_addr   = '0;
    in_ch.is_store    = 1'b0;
    in_ch.kernel_mode = 1'b0;
    in_ch.read_data   = '0;
    out_ch.ready      = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = REG_PAGING_ENABLE;
    cfg_wdata         = '0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    sink_hold_go      = 1'b0;
    mismatches        = 0;
    rst_n             = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_traffic();

    $display("Covered %0d requests and %0d table words; %0d results checked, %0d faults.",
             n_requests, n_words, n_results, n_faults);
    $display("%0d register settings, idle and stall on both sides, one long output hold.",
             n_settings);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
